### rtl/fzcd_pkg.sv
// ----------------------------------------------------------------------------
// fzcd_pkg
// Shared types, widths and codes of the fsk zero-crossing demodulator.
// ----------------------------------------------------------------------------
package fzcd_pkg;

   // sizing
   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 32;

   localparam int THR_W   = 16;
   localparam int SPB_W   = 16;
   localparam int HP_W    = 20;
   localparam int HALF_W  = 8;
   localparam int QUIET_W = 17;
   localparam int SPAN_W  = 21;
   localparam int FRAC_W  = 4;
   localparam int T_W     = SPAN_W + FRAC_W;
   localparam int SX_W    = SAMPLE_BITS + 1;
   localparam int CMP_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
   localparam int DIFF_W  = (INDEX_BITS > SPAN_W) ? INDEX_BITS : SPAN_W;
   localparam int MUL_A_W = (INDEX_BITS > T_W) ? INDEX_BITS : T_W;
   localparam int MUL_B_W = (SAMPLE_BITS > HP_W) ? SAMPLE_BITS : HP_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DVD_W   = INDEX_BITS + SAMPLE_BITS;
   localparam int DIV_CNT_W = $clog2(INDEX_BITS + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SX_W-1:0]        sx_type;
   typedef logic signed [CMP_W-1:0]       cmp_type;
   typedef logic signed [THR_W-1:0]       thr_type;
   typedef logic [SAMPLE_BITS-1:0]        mag_type;
   typedef logic [SX_W-1:0]               magx_type;
   typedef logic [INDEX_BITS-1:0]         index_type;
   typedef logic [DIFF_W-1:0]             diff_type;
   typedef logic [SPAN_W-1:0]             span_type;
   typedef logic [T_W-1:0]                t_type;
   typedef logic [HP_W-1:0]               hp_type;
   typedef logic [HALF_W-1:0]             half_type;
   typedef logic [SPB_W-1:0]              spb_type;
   typedef logic [QUIET_W-1:0]            quiet_type;
   typedef logic [MUL_A_W-1:0]            opa_type;
   typedef logic [MUL_B_W-1:0]            opb_type;
   typedef logic [PROD_W-1:0]             prod_type;
   typedef logic [DVD_W-1:0]              dvd_type;
   typedef logic [DIV_CNT_W-1:0]          div_cnt_type;
   typedef logic [CSR_IDX_W-1:0]          csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]         csr_data_type;

   // register indexes
   localparam csr_idx_type CSR_HIGH_THR   = 3'd0;
   localparam csr_idx_type CSR_LOW_THR    = 3'd1;
   localparam csr_idx_type CSR_SPB        = 3'd2;
   localparam csr_idx_type CSR_MARK_HP    = 3'd3;
   localparam csr_idx_type CSR_SPACE_HP   = 3'd4;
   localparam csr_idx_type CSR_MARK_HALF  = 3'd5;
   localparam csr_idx_type CSR_SPACE_HALF = 3'd6;

   // register reset values
   localparam thr_type  RST_HIGH_THR   = 16'sd8192;
   localparam thr_type  RST_LOW_THR    = -16'sd8192;
   localparam spb_type  RST_SPB        = 16'd147;
   localparam hp_type   RST_MARK_HP    = 20'd471;
   localparam hp_type   RST_SPACE_HP   = 20'd1131;
   localparam half_type RST_MARK_HALF  = 8'd10;
   localparam half_type RST_SPACE_HALF = 8'd4;

   localparam span_type SPAN_MAX  = 21'h100000;
   localparam quiet_type QUIET_MAX = 17'h1FFFF;
   localparam half_type RUN_MAX   = 8'd255;

   // tone codes
   typedef logic [1:0] tone_type;
   localparam tone_type TONE_NONE  = 2'd0;
   localparam tone_type TONE_MARK  = 2'd1;
   localparam tone_type TONE_SPACE = 2'd2;

   // sign codes
   typedef logic [1:0] sign_type;
   localparam sign_type SIGN_ZERO = 2'b00;
   localparam sign_type SIGN_POS  = 2'b01;
   localparam sign_type SIGN_NEG  = 2'b10;

   // run counter control and status
   typedef struct packed {
      logic     half_en;
      tone_type half_tone;
      logic     flush;
   } run_cmd_type;

   typedef struct packed {
      logic emit;
      logic emit_bit;
   } run_stat_type;

   function automatic sign_type sign_of(input sample_type x);
      sign_type s;
      if (x[SAMPLE_BITS-1]) begin
         s = SIGN_NEG;
      end else if (x != '0) begin
         s = SIGN_POS;
      end else begin
         s = SIGN_ZERO;
      end
      return s;
   endfunction

endpackage

### rtl/fzcd_ifs.sv
// ----------------------------------------------------------------------------
// fzcd channel interfaces
// Request channel (sample or flush) and response channel (one bit).
// ----------------------------------------------------------------------------
interface fzcd_req_if;
   logic                   valid;
   logic                   ready;
   logic                   action;
   fzcd_pkg::sample_type   sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);
endinterface

interface fzcd_rsp_if;
   logic valid;
   logic ready;
   logic bit_res;

   modport source (output valid, output bit_res, input ready);
   modport sink   (input valid, input bit_res, output ready);
endinterface

### rtl/fzcd_mul.sv
// ----------------------------------------------------------------------------
// fzcd_mul
// Shared registered multiplier, used for the interpolation product and
// both cross products of the tone decision.
// ----------------------------------------------------------------------------
module fzcd_mul (
   input  logic                 clock,
   input  fzcd_pkg::opa_type    op_a,
   input  fzcd_pkg::opb_type    op_b,
   output fzcd_pkg::prod_type   prod
);

   fzcd_pkg::prod_type prod_ff;

   // one product per cycle, registered
   always_ff @(posedge clock) begin
      prod_ff <= fzcd_pkg::prod_type'(op_a) * fzcd_pkg::prod_type'(op_b);
   end

   assign prod = prod_ff;

endmodule

### rtl/fzcd_div.sv
// ----------------------------------------------------------------------------
// fzcd_div
// Restoring serial divider, one quotient bit per cycle. The upper part of
// the dividend must be below the divisor so the quotient fits an index.
// ----------------------------------------------------------------------------
module fzcd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fzcd_pkg::dvd_type      dividend,
   input  fzcd_pkg::mag_type      divisor,
   output logic                   done,
   output fzcd_pkg::index_type    quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   fzcd_pkg::div_cnt_type cnt_ff, cnt_in;
   fzcd_pkg::mag_type     rem_ff, rem_in;
   fzcd_pkg::index_type   quo_ff, quo_in;
   fzcd_pkg::magx_type    shifted;
   fzcd_pkg::magx_type    trial;
   logic                  ge;

   // one shift-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[fzcd_pkg::INDEX_BITS-1]};
      ge      = shifted >= fzcd_pkg::magx_type'(divisor);
      trial   = shifted - fzcd_pkg::magx_type'(divisor);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = fzcd_pkg::div_cnt_type'(fzcd_pkg::INDEX_BITS);
         rem_in  = dividend[fzcd_pkg::DVD_W-1:fzcd_pkg::INDEX_BITS];
         quo_in  = dividend[fzcd_pkg::INDEX_BITS-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? trial[fzcd_pkg::SAMPLE_BITS-1:0] : shifted[fzcd_pkg::SAMPLE_BITS-1:0];
         quo_in = {quo_ff[fzcd_pkg::INDEX_BITS-2:0], ge};
         cnt_in = cnt_ff - fzcd_pkg::div_cnt_type'(1);
         if (cnt_ff == fzcd_pkg::div_cnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/fzcd_run.sv
// ----------------------------------------------------------------------------
// fzcd_run
// Run counter of equal half periods; decides when a bit is complete.
// ----------------------------------------------------------------------------
module fzcd_run (
   input  logic                    clock,
   input  logic                    reset,
   input  fzcd_pkg::half_type      mark_halves,
   input  fzcd_pkg::half_type      space_halves,
   input  fzcd_pkg::run_cmd_type   cmd,
   output fzcd_pkg::run_stat_type  stat
);

   fzcd_pkg::tone_type tone_ff, tone_in;
   fzcd_pkg::half_type len_ff, len_in;
   fzcd_pkg::tone_type tone_eff;
   fzcd_pkg::half_type len_eff;
   fzcd_pkg::half_type len_inc;
   fzcd_pkg::half_type need;

   // next run state and emitted bit
   always_comb begin
      tone_eff = (tone_ff == fzcd_pkg::TONE_NONE) ? cmd.half_tone : tone_ff;
      len_eff  = (tone_ff == fzcd_pkg::TONE_NONE) ? '0 : len_ff;
      need     = (tone_eff == fzcd_pkg::TONE_MARK) ? mark_halves : space_halves;
      len_inc  = (len_eff < fzcd_pkg::RUN_MAX) ? len_eff + fzcd_pkg::half_type'(1) : len_eff;

      tone_in       = tone_ff;
      len_in        = len_ff;
      stat.emit     = 1'b0;
      stat.emit_bit = 1'b0;
      if (cmd.flush) begin
         stat.emit     = tone_ff != fzcd_pkg::TONE_NONE;
         stat.emit_bit = tone_ff == fzcd_pkg::TONE_MARK;
         tone_in       = fzcd_pkg::TONE_NONE;
         len_in        = '0;
      end else if (cmd.half_en) begin
         if (cmd.half_tone == tone_eff) begin
            tone_in = tone_eff;
            // same tone: extend the run, complete a bit at the threshold
            if (len_inc >= need) begin
               len_in        = '0;
               stat.emit     = 1'b1;
               stat.emit_bit = tone_eff == fzcd_pkg::TONE_MARK;
            end else begin
               len_in = len_inc;
            end
         end else if (len_eff != '0) begin
            // tone change closes the pending bit
            tone_in       = cmd.half_tone;
            len_in        = '0;
            stat.emit     = 1'b1;
            stat.emit_bit = tone_eff == fzcd_pkg::TONE_MARK;
         end else begin
            tone_in = cmd.half_tone;
            len_in  = fzcd_pkg::half_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff <= fzcd_pkg::TONE_NONE;
         len_ff  <= '0;
      end else begin
         tone_ff <= tone_in;
         len_ff  <= len_in;
      end
   end

endmodule

### rtl/fsk_zero_crossing_demodulator_core.sv
// ----------------------------------------------------------------------------
// fsk_zero_crossing_demodulator_core
// Recovers bits from signed audio samples by timing zero crossings.
//
// One request is taken at a time. A flush, a quiet sample, or a significant
// sample that places no crossing is handled in the evaluate state and goes
// on to the output state when it releases a bit. A sample that places a
// crossing passes through the multiply and divider states, where a serial
// divider computes the interpolated crossing position, and one shared
// multiplier is used three times in turn, once for the interpolation product
// and twice for the mark/space distance comparison. It ends at the crossing
// state when there is no earlier crossing to time it against, and goes on
// to the output state when the half period completes a bit. A bit that
// completes goes to a response register, so the next request can enter while
// the bit waits; a second bit stalls the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module fsk_zero_crossing_demodulator_core (
   input  logic                    clock,
   input  logic                    reset,
   fzcd_req_if.sink                req_chan,
   fzcd_rsp_if.source              rsp_chan,
   input  logic                    csr_we,
   input  fzcd_pkg::csr_idx_type   csr_index,
   input  fzcd_pkg::csr_data_type  csr_wdata
);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EVAL  = 4'd1;
   localparam logic [3:0] ST_MULD  = 4'd2;
   localparam logic [3:0] ST_DIVS  = 4'd3;
   localparam logic [3:0] ST_DIVW  = 4'd4;
   localparam logic [3:0] ST_CROSS = 4'd5;
   localparam logic [3:0] ST_CMPA  = 4'd6;
   localparam logic [3:0] ST_CMPB  = 4'd7;
   localparam logic [3:0] ST_CMPC  = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   // configuration registers
   fzcd_pkg::thr_type  high_thr_ff;
   fzcd_pkg::thr_type  low_thr_ff;
   fzcd_pkg::spb_type  spb_ff;
   fzcd_pkg::hp_type   mark_hp_ff;
   fzcd_pkg::hp_type   space_hp_ff;
   fzcd_pkg::half_type mark_half_ff;
   fzcd_pkg::half_type space_half_ff;

   // control state
   logic [3:0]          state_ff, state_in;
   fzcd_pkg::index_type cnt_ff, cnt_in;
   fzcd_pkg::quiet_type quiet_ff, quiet_in;
   logic                psv_ff, psv_in;
   logic                pcv_ff, pcv_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload state
   logic                 act_ff, act_in;
   fzcd_pkg::sample_type smp_ff, smp_in;
   fzcd_pkg::index_type  psi_ff, psi_in;
   fzcd_pkg::sample_type psval_ff, psval_in;
   fzcd_pkg::index_type  pci_ff, pci_in;
   fzcd_pkg::index_type  base_ff, base_in;
   fzcd_pkg::mag_type    divisor_ff, divisor_in;
   fzcd_pkg::opa_type    opa_ff, opa_in;
   fzcd_pkg::opb_type    opb_ff, opb_in;
   fzcd_pkg::t_type      ds_ff, ds_in;
   fzcd_pkg::prod_type   p1_ff, p1_in;
   logic                 out_bit_ff, out_bit_in;
   logic                 rsp_bit_ff, rsp_bit_in;

   // unit connections
   fzcd_pkg::prod_type     prod;
   logic                   div_start;
   logic                   div_done;
   fzcd_pkg::index_type    quotient;
   fzcd_pkg::run_cmd_type  run_cmd;
   fzcd_pkg::run_stat_type run_stat;

   // working values
   fzcd_pkg::cmp_type   v_x;
   logic                is_hi;
   logic                is_lo;
   fzcd_pkg::index_type cnt_n;
   fzcd_pkg::quiet_type quiet_n;
   fzcd_pkg::sx_type    pv_x;
   fzcd_pkg::sx_type    pv_abs;
   fzcd_pkg::sx_type    gap_x;
   fzcd_pkg::sx_type    gap_abs;
   fzcd_pkg::index_type sig_gap;
   fzcd_pkg::index_type cross_idx;
   fzcd_pkg::index_type half_gap;
   fzcd_pkg::diff_type  half_gap_x;
   fzcd_pkg::span_type  span;
   fzcd_pkg::t_type     t_val;
   fzcd_pkg::t_type     m_val;
   fzcd_pkg::t_type     s_val;
   fzcd_pkg::t_type     dm;
   fzcd_pkg::t_type     ds;

   fzcd_mul u_mul (
      .clock (clock),
      .op_a  (opa_ff),
      .op_b  (opb_ff),
      .prod  (prod)
   );

   fzcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[fzcd_pkg::DVD_W-1:0]),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   fzcd_run u_run (
      .clock        (clock),
      .reset        (reset),
      .mark_halves  (mark_half_ff),
      .space_halves (space_half_ff),
      .cmd          (run_cmd),
      .stat         (run_stat)
   );

   // sample classification and interpolation operands
   always_comb begin
      v_x     = fzcd_pkg::cmp_type'(smp_ff);
      is_hi   = v_x >= fzcd_pkg::cmp_type'(high_thr_ff);
      is_lo   = v_x <= fzcd_pkg::cmp_type'(low_thr_ff);
      cnt_n   = cnt_ff + fzcd_pkg::index_type'(1);
      quiet_n = (quiet_ff < fzcd_pkg::QUIET_MAX) ? quiet_ff + fzcd_pkg::quiet_type'(1)
                                                 : quiet_ff;
      pv_x    = fzcd_pkg::sx_type'(psval_ff);
      pv_abs  = pv_x[fzcd_pkg::SAMPLE_BITS] ? -pv_x : pv_x;
      gap_x   = fzcd_pkg::sx_type'(psval_ff) - fzcd_pkg::sx_type'(smp_ff);
      gap_abs = gap_x[fzcd_pkg::SAMPLE_BITS] ? -gap_x : gap_x;
      sig_gap = cnt_n - psi_ff;
   end

   // half period and distances to the nominal tones
   always_comb begin
      cross_idx  = base_ff + quotient;
      half_gap   = cross_idx - pci_ff;
      half_gap_x = fzcd_pkg::diff_type'(half_gap);
      span       = (half_gap_x > fzcd_pkg::diff_type'(fzcd_pkg::SPAN_MAX))
                   ? fzcd_pkg::SPAN_MAX : half_gap_x[fzcd_pkg::SPAN_W-1:0];
      t_val      = {span, {fzcd_pkg::FRAC_W{1'b0}}};
      m_val      = fzcd_pkg::t_type'(mark_hp_ff);
      s_val      = fzcd_pkg::t_type'(space_hp_ff);
      dm         = (t_val >= m_val) ? t_val - m_val : m_val - t_val;
      ds         = (t_val >= s_val) ? t_val - s_val : s_val - t_val;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      quiet_in     = quiet_ff;
      psv_in       = psv_ff;
      pcv_in       = pcv_ff;
      act_in       = act_ff;
      smp_in       = smp_ff;
      psi_in       = psi_ff;
      psval_in     = psval_ff;
      pci_in       = pci_ff;
      base_in      = base_ff;
      divisor_in   = divisor_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      ds_in        = ds_ff;
      p1_in        = p1_ff;
      out_bit_in   = out_bit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_bit_in   = rsp_bit_ff;
      run_cmd      = '0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               smp_in   = req_chan.sample;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (act_ff) begin
               // flush request: emit pending bit and clear
               run_cmd.flush = 1'b1;
               out_bit_in    = run_stat.emit_bit;
               cnt_in        = '0;
               quiet_in      = '0;
               psv_in        = 1'b0;
               psi_in        = '0;
               psval_in      = '0;
               pcv_in        = 1'b0;
               pci_in        = '0;
               state_in      = run_stat.emit ? ST_OUT : ST_IDLE;
            end else if (!is_hi && !is_lo) begin
               // quiet sample
               state_in = ST_IDLE;
               if (quiet_n > fzcd_pkg::quiet_type'(spb_ff)) begin
                  run_cmd.flush = 1'b1;
                  out_bit_in    = run_stat.emit_bit;
                  cnt_in        = '0;
                  quiet_in      = '0;
                  psv_in        = 1'b0;
                  psi_in        = '0;
                  psval_in      = '0;
                  pcv_in        = 1'b1;
                  pci_in        = '0;
                  state_in      = run_stat.emit ? ST_OUT : ST_IDLE;
               end else begin
                  cnt_in   = cnt_n;
                  quiet_in = quiet_n;
                  if (!psv_ff) begin
                     pcv_in = 1'b1;
                     pci_in = cnt_n;
                  end
               end
            end else begin
               // significant sample
               cnt_in   = cnt_n;
               quiet_in = '0;
               psv_in   = 1'b1;
               psi_in   = cnt_n;
               psval_in = smp_ff;
               state_in = ST_IDLE;
               if (psv_ff && (fzcd_pkg::sign_of(psval_ff) != fzcd_pkg::sign_of(smp_ff))) begin
                  base_in    = psi_ff;
                  divisor_in = gap_abs[fzcd_pkg::SAMPLE_BITS-1:0];
                  opa_in     = fzcd_pkg::opa_type'(sig_gap);
                  opb_in     = fzcd_pkg::opb_type'(pv_abs[fzcd_pkg::SAMPLE_BITS-1:0]);
                  state_in   = ST_MULD;
               end
            end
         end

         ST_MULD: begin
            state_in = ST_DIVS;
         end

         ST_DIVS: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end

         ST_DIVW: begin
            if (div_done) begin
               state_in = ST_CROSS;
            end
         end

         ST_CROSS: begin
            pcv_in = 1'b1;
            pci_in = cross_idx;
            if (pcv_ff) begin
               opa_in   = fzcd_pkg::opa_type'(dm);
               opb_in   = fzcd_pkg::opb_type'(space_hp_ff);
               ds_in    = ds;
               state_in = ST_CMPA;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_CMPA: begin
            opa_in   = fzcd_pkg::opa_type'(ds_ff);
            opb_in   = fzcd_pkg::opb_type'(mark_hp_ff);
            state_in = ST_CMPB;
         end

         ST_CMPB: begin
            p1_in    = prod;
            state_in = ST_CMPC;
         end

         ST_CMPC: begin
            // mark when |t-M|*S < |t-S|*M, ties go to space
            run_cmd.half_en   = 1'b1;
            run_cmd.half_tone = (p1_ff < prod) ? fzcd_pkg::TONE_MARK : fzcd_pkg::TONE_SPACE;
            out_bit_in        = run_stat.emit_bit;
            state_in          = run_stat.emit ? ST_OUT : ST_IDLE;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = out_bit_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         quiet_ff     <= '0;
         psv_ff       <= 1'b0;
         pcv_ff       <= 1'b0;
         psi_ff       <= '0;
         psval_ff     <= '0;
         pci_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         quiet_ff     <= quiet_in;
         psv_ff       <= psv_in;
         pcv_ff       <= pcv_in;
         psi_ff       <= psi_in;
         psval_ff     <= psval_in;
         pci_ff       <= pci_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      smp_ff     <= smp_in;
      base_ff    <= base_in;
      divisor_ff <= divisor_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      ds_ff      <= ds_in;
      p1_ff      <= p1_in;
      out_bit_ff <= out_bit_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff   <= fzcd_pkg::RST_HIGH_THR;
         low_thr_ff    <= fzcd_pkg::RST_LOW_THR;
         spb_ff        <= fzcd_pkg::RST_SPB;
         mark_hp_ff    <= fzcd_pkg::RST_MARK_HP;
         space_hp_ff   <= fzcd_pkg::RST_SPACE_HP;
         mark_half_ff  <= fzcd_pkg::RST_MARK_HALF;
         space_half_ff <= fzcd_pkg::RST_SPACE_HALF;
      end else if (csr_we) begin
         unique case (csr_index)
            fzcd_pkg::CSR_HIGH_THR:   high_thr_ff   <= csr_wdata[fzcd_pkg::THR_W-1:0];
            fzcd_pkg::CSR_LOW_THR:    low_thr_ff    <= csr_wdata[fzcd_pkg::THR_W-1:0];
            fzcd_pkg::CSR_SPB:        spb_ff        <= csr_wdata[fzcd_pkg::SPB_W-1:0];
            fzcd_pkg::CSR_MARK_HP:    mark_hp_ff    <= csr_wdata[fzcd_pkg::HP_W-1:0];
            fzcd_pkg::CSR_SPACE_HP:   space_hp_ff   <= csr_wdata[fzcd_pkg::HP_W-1:0];
            fzcd_pkg::CSR_MARK_HALF:  mark_half_ff  <= csr_wdata[fzcd_pkg::HALF_W-1:0];
            fzcd_pkg::CSR_SPACE_HALF: space_half_ff <= csr_wdata[fzcd_pkg::HALF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready   = state_ff == ST_IDLE;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.bit_res = rsp_bit_ff;

endmodule

### rtl/fzcd_checker.sv
// ----------------------------------------------------------------------------
// fzcd_checker
// Port-level checks of the demodulator core, bound to the top level.
// ----------------------------------------------------------------------------
module fzcd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_bit_res
);

   // a stalled response stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its bit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_bit_res))
      else $error("response bit changed while stalled");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a bit never shows up in the cycle right after its request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response too early after request");

endmodule

bind fsk_zero_crossing_demodulator_core fzcd_checker u_fzcd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_bit_res (rsp_chan.bit_res)
);

### verif/fsk_zero_crossing_demodulator_core_tb.sv
// ----------------------------------------------------------------------------
// fsk_zero_crossing_demodulator_core_tb
// Self-checking bench: directed threshold, sign and register corner cases,
// then tone bursts mixed with noise and flushes under several register
// settings and handshake pacings. Every response bit is checked in order
// against a cycle-free demodulator mirror updated on each accepted request.
// ----------------------------------------------------------------------------
module fsk_zero_crossing_demodulator_core_tb;

   localparam int SETTLE_CYCLES = 64;
   localparam int TIMEOUT_TIME  = 5_000_000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   fzcd_pkg::csr_idx_type  csr_index = '0;
   fzcd_pkg::csr_data_type csr_wdata = '0;

   fzcd_req_if req_bus ();
   fzcd_rsp_if rsp_bus ();

   // pacing controls
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles   = 0;
   int items_left    = 0;
   int mismatches    = 0;
   bit wave_neg      = 1'b0;

   // register mirror
   fzcd_pkg::thr_type  cfg_high;
   fzcd_pkg::thr_type  cfg_low;
   fzcd_pkg::spb_type  cfg_spb;
   fzcd_pkg::hp_type   cfg_mark_hp;
   fzcd_pkg::hp_type   cfg_space_hp;
   fzcd_pkg::half_type cfg_mark_half;
   fzcd_pkg::half_type cfg_space_half;

   // demodulator state mirror
   fzcd_pkg::index_type  m_count;
   fzcd_pkg::quiet_type  m_quiet;
   logic                 m_sig_ok;
   fzcd_pkg::index_type  m_sig_idx;
   fzcd_pkg::sample_type m_sig_val;
   logic                 m_cross_ok;
   fzcd_pkg::index_type  m_cross_idx;
   fzcd_pkg::tone_type   m_tone;
   fzcd_pkg::half_type   m_run;

   // bits still owed by the block, oldest first
   logic pending_bits[$];

   fsk_zero_crossing_demodulator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // demodulator mirror
   // ------------------------------------------------------------------------
   function automatic void clear_demod();
      m_count     = '0;
      m_quiet     = '0;
      m_sig_ok    = 1'b0;
      m_sig_idx   = '0;
      m_sig_val   = '0;
      m_cross_ok  = 1'b0;
      m_cross_idx = '0;
      m_tone      = fzcd_pkg::TONE_NONE;
      m_run       = '0;
   endfunction

   function automatic void reset_mirror();
      cfg_high       = fzcd_pkg::RST_HIGH_THR;
      cfg_low        = fzcd_pkg::RST_LOW_THR;
      cfg_spb        = fzcd_pkg::RST_SPB;
      cfg_mark_hp    = fzcd_pkg::RST_MARK_HP;
      cfg_space_hp   = fzcd_pkg::RST_SPACE_HP;
      cfg_mark_half  = fzcd_pkg::RST_MARK_HALF;
      cfg_space_half = fzcd_pkg::RST_SPACE_HALF;
      clear_demod();
   endfunction

   // pending tone goes out as a bit, then everything restarts
   function automatic void flush_demod();
      if (m_tone != fzcd_pkg::TONE_NONE) begin
         pending_bits.push_back(m_tone == fzcd_pkg::TONE_MARK);
      end
      clear_demod();
   endfunction

   // run counting of classified half periods
   function automatic void count_half(fzcd_pkg::tone_type tone);
      fzcd_pkg::half_type need;
      if (m_tone == fzcd_pkg::TONE_NONE) begin
         m_tone = tone;
         m_run  = '0;
      end
      need = (m_tone == fzcd_pkg::TONE_MARK) ? cfg_mark_half : cfg_space_half;
      if (tone == m_tone) begin
         if (m_run < fzcd_pkg::RUN_MAX) begin
            m_run = m_run + fzcd_pkg::half_type'(1);
         end
         if (m_run >= need) begin
            m_run = '0;
            pending_bits.push_back(m_tone == fzcd_pkg::TONE_MARK);
         end
      end else if (m_run >= fzcd_pkg::half_type'(1)) begin
         pending_bits.push_back(m_tone == fzcd_pkg::TONE_MARK);
         m_tone = tone;
         m_run  = '0;
      end else begin
         m_tone = tone;
         m_run  = fzcd_pkg::half_type'(1);
      end
   endfunction

   // half period since the last crossing, classed by relative distance
   function automatic void place_crossing(fzcd_pkg::index_type at);
      fzcd_pkg::index_type gap;
      longint unsigned span, t, m, s, dm, ds;
      if (m_cross_ok) begin
         gap  = at - m_cross_idx;
         span = gap;
         if (span > (64'd1 << 20)) begin
            span = 64'd1 << 20;
         end
         t  = span << 4;
         m  = cfg_mark_hp;
         s  = cfg_space_hp;
         dm = (t >= m) ? t - m : m - t;
         ds = (t >= s) ? t - s : s - t;
         count_half((dm * s < ds * m) ? fzcd_pkg::TONE_MARK : fzcd_pkg::TONE_SPACE);
      end
      m_cross_ok  = 1'b1;
      m_cross_idx = at;
   endfunction

   // one accepted request
   function automatic void track_demod(logic flush, fzcd_pkg::sample_type smp);
      logic hi, lo;
      longint pv, cv;
      longint unsigned d, a, b, off;
      fzcd_pkg::index_type gap;
      if (flush) begin
         flush_demod();
         return;
      end
      m_count = m_count + fzcd_pkg::index_type'(1);
      hi = (smp >= cfg_high);
      lo = (smp <= cfg_low);
      if (!hi && !lo) begin
         if (m_quiet < fzcd_pkg::QUIET_MAX) begin
            m_quiet = m_quiet + fzcd_pkg::quiet_type'(1);
         end
         if (m_quiet > fzcd_pkg::quiet_type'(cfg_spb)) begin
            flush_demod();
         end
         // bootstrap crossing before any significant sample
         if (!m_sig_ok) begin
            m_cross_ok  = 1'b1;
            m_cross_idx = m_count;
         end
         return;
      end
      m_quiet = '0;
      pv = m_sig_val;
      cv = smp;
      if (m_sig_ok && (((pv > 0) != (cv > 0)) || ((pv < 0) != (cv < 0)))) begin
         gap = m_count - m_sig_idx;
         d   = gap;
         a   = (pv < 0) ? -pv : pv;
         b   = (pv > cv) ? pv - cv : cv - pv;
         off = (d / b) * a + ((d % b) * a) / b;
         place_crossing(fzcd_pkg::index_type'(m_sig_idx + off));
      end
      m_sig_ok  = 1'b1;
      m_sig_idx = m_count;
      m_sig_val = smp;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic fzcd_pkg::sample_type loud_sample(bit neg);
      int top, bottom;
      top    = (cfg_low < 0) ? int'(cfg_low) : -1;
      bottom = (cfg_high > 0) ? int'(cfg_high) : 1;
      return neg ? fzcd_pkg::sample_type'(pick(-32768, top))
                 : fzcd_pkg::sample_type'(pick(bottom, 32767));
   endfunction

   function automatic fzcd_pkg::sample_type quiet_sample(bit neg);
      int lo, hi;
      lo = int'(cfg_low) + 1;
      hi = int'(cfg_high) - 1;
      if (lo > hi) begin
         return loud_sample(neg);
      end
      return fzcd_pkg::sample_type'(pick(lo, hi));
   endfunction

   // one request, with an optional sender gap in front of it
   task automatic send_req(logic flush, fzcd_pkg::sample_type smp);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock) req_bus.valid <= 1'b0;
         repeat ($urandom_range(2)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.action <= flush;
      req_bus.sample <= smp;
      do @(posedge clock); while (!req_bus.ready);
      track_demod(flush, smp);
      items_left--;
   endtask

   // sender stops until every owed bit has come back
   task automatic drain_bits(int settle);
      @(negedge clock) req_bus.valid <= 1'b0;
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic wr_reg(fzcd_pkg::csr_idx_type idx, fzcd_pkg::csr_data_type data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // all registers, written only once the block has gone idle
   task automatic load_config(int hi, int lo, int spb, int mhp, int shp, int mh, int sh);
      drain_bits(SETTLE_CYCLES);
      wr_reg(fzcd_pkg::CSR_HIGH_THR, fzcd_pkg::csr_data_type'(hi & 'hFFFF));
      wr_reg(fzcd_pkg::CSR_LOW_THR, fzcd_pkg::csr_data_type'(lo & 'hFFFF));
      wr_reg(fzcd_pkg::CSR_SPB, fzcd_pkg::csr_data_type'(spb));
      wr_reg(fzcd_pkg::CSR_MARK_HP, fzcd_pkg::csr_data_type'(mhp));
      wr_reg(fzcd_pkg::CSR_SPACE_HP, fzcd_pkg::csr_data_type'(shp));
      wr_reg(fzcd_pkg::CSR_MARK_HALF, fzcd_pkg::csr_data_type'(mh));
      wr_reg(fzcd_pkg::CSR_SPACE_HALF, fzcd_pkg::csr_data_type'(sh));
      @(negedge clock) csr_we <= 1'b0;
      cfg_high       = fzcd_pkg::thr_type'(hi);
      cfg_low        = fzcd_pkg::thr_type'(lo);
      cfg_spb        = fzcd_pkg::spb_type'(spb);
      cfg_mark_hp    = fzcd_pkg::hp_type'(mhp);
      cfg_space_hp   = fzcd_pkg::hp_type'(shp);
      cfg_mark_half  = fzcd_pkg::half_type'(mh);
      cfg_space_half = fzcd_pkg::half_type'(sh);
   endtask

   task automatic load_random_config();
      load_config(pick(0, 20000), pick(-20000, 0), pick(3, 20), pick(16, 80),
                  pick(81, 200), pick(1, 4), pick(1, 3));
   endtask

   task automatic set_pacing(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // a run of alternating half periods near one nominal tone, with jitter
   task automatic send_tone_run();
      fzcd_pkg::tone_type tone;
      int halves, base, len;
      tone   = $urandom_range(1) ? fzcd_pkg::TONE_MARK : fzcd_pkg::TONE_SPACE;
      halves = (tone == fzcd_pkg::TONE_MARK) ? int'(cfg_mark_half) : int'(cfg_space_half);
      base   = (tone == fzcd_pkg::TONE_MARK) ? int'(cfg_mark_hp) : int'(cfg_space_hp);
      base   = base >> 4;
      if (halves < 1) halves = 1;
      if (halves > 12) halves = 12;
      if (base < 1) base = 1;
      if (base > 200) base = 200;
      halves = halves * pick(1, 3);
      repeat (halves) begin
         len = pick((base > 1) ? base - 1 : 1, base + 1);
         repeat (len) begin
            if (items_left <= 0) return;
            if ($urandom_range(99) < 8) begin
               send_req(1'b0, quiet_sample(wave_neg));
            end else begin
               send_req(1'b0, loud_sample(wave_neg));
            end
         end
         wave_neg = !wave_neg;
      end
   endtask

   // mostly well-formed tone runs, some raw noise and flushes
   task automatic send_mix(int count);
      int r;
      items_left = count;
      while (items_left > 0) begin
         r = $urandom_range(99);
         if (r < 80) begin
            send_tone_run();
         end else if (r < 95) begin
            send_req(1'b0, fzcd_pkg::sample_type'($urandom));
         end else begin
            send_req(1'b1, fzcd_pkg::sample_type'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset register values, samples right at the thresholds
   task automatic test_reset_values();
      send_req(1'b0, fzcd_pkg::sample_type'(8191));
      send_req(1'b0, fzcd_pkg::sample_type'(8192));
      send_req(1'b0, fzcd_pkg::sample_type'(-8191));
      send_req(1'b0, fzcd_pkg::sample_type'(-8192));
      send_req(1'b1, fzcd_pkg::sample_type'(0));
   endtask

   // full-scale samples, flush with no tone, quiet-run flush and restart
   task automatic test_sample_extremes();
      load_config(100, -100, 2, 32, 64, 1, 1);
      send_req(1'b1, fzcd_pkg::sample_type'(-32768));
      send_req(1'b0, fzcd_pkg::sample_type'(0));
      send_req(1'b0, fzcd_pkg::sample_type'(32767));
      send_req(1'b0, fzcd_pkg::sample_type'(-32768));
      send_req(1'b0, fzcd_pkg::sample_type'(32767));
      send_req(1'b0, fzcd_pkg::sample_type'(-32768));
      repeat (3) send_req(1'b0, fzcd_pkg::sample_type'(99));
      send_req(1'b0, fzcd_pkg::sample_type'(150));
      send_req(1'b0, fzcd_pkg::sample_type'(-150));
   endtask

   // zero counts as significant and as a sign of its own
   task automatic test_zero_valued_sample();
      load_config(0, -100, 16, 32, 64, 1, 1);
      send_req(1'b0, fzcd_pkg::sample_type'(0));
      send_req(1'b0, fzcd_pkg::sample_type'(-300));
      send_req(1'b0, fzcd_pkg::sample_type'(0));
      send_req(1'b0, fzcd_pkg::sample_type'(50));
      send_req(1'b0, fzcd_pkg::sample_type'(-5));
      send_req(1'b0, fzcd_pkg::sample_type'(-300));
      send_req(1'b1, fzcd_pkg::sample_type'(0));
   endtask

   // zero halves per bit, zero half period, then mark/space ties
   task automatic test_degenerate_config();
      load_config(100, -100, 16, 0, 1048575, 0, 0);
      send_req(1'b0, fzcd_pkg::sample_type'(500));
      send_req(1'b0, fzcd_pkg::sample_type'(-500));
      send_req(1'b0, fzcd_pkg::sample_type'(500));
      send_req(1'b0, fzcd_pkg::sample_type'(-500));
      send_req(1'b0, fzcd_pkg::sample_type'(500));
      load_config(100, -100, 16, 48, 48, 1, 1);
      send_req(1'b0, fzcd_pkg::sample_type'(-500));
      send_req(1'b0, fzcd_pkg::sample_type'(500));
      send_req(1'b0, fzcd_pkg::sample_type'(-500));
      send_req(1'b1, fzcd_pkg::sample_type'(0));
   endtask

   task automatic test_free_running();
      load_config(1000, -1000, 6, 48, 112, 2, 1);
      set_pacing(0, 0);
      send_mix(250);
   endtask

   task automatic test_sender_gaps();
      load_config(4000, -200, 10, 40, 96, 3, 2);
      set_pacing(59, 0);
      send_mix(250);
   endtask

   task automatic test_receiver_stalls();
      load_random_config();
      set_pacing(0, 59);
      send_mix(250);
   endtask

   task automatic test_mixed_gaps();
      load_random_config();
      set_pacing(13, 13);
      send_mix(250);
   endtask

   // long receiver hold-off fills the block, then a full drain mid-stream
   task automatic test_back_pressure();
      load_config(1000, -1000, 6, 32, 64, 1, 1);
      set_pacing(0, 0);
      @(posedge clock);
      hold_cycles = 400;
      send_mix(80);
      drain_bits(0);
      send_mix(70);
   endtask

   // only full scale is significant, then everything is
   task automatic test_threshold_extremes();
      set_pacing(13, 13);
      load_config(32767, -32768, 65535, 16, 1048575, 255, 255);
      send_mix(100);
      load_config(-32768, 32767, 1, 1048575, 16, 1, 255);
      send_mix(100);
   endtask

   task automatic test_nominal_tones();
      load_config(int'(fzcd_pkg::RST_HIGH_THR), int'(fzcd_pkg::RST_LOW_THR),
                  int'(fzcd_pkg::RST_SPB), int'(fzcd_pkg::RST_MARK_HP),
                  int'(fzcd_pkg::RST_SPACE_HP), int'(fzcd_pkg::RST_MARK_HALF),
                  int'(fzcd_pkg::RST_SPACE_HALF));
      set_pacing(0, 0);
      send_mix(300);
   endtask

   // ------------------------------------------------------------------------
   // receiver pacing, hold-off counted here
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // response check against the oldest owed bit
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_bits.size() == 0) begin
            $display("%0t: unexpected bit, expected none, got %0b", $time, rsp_bus.bit_res);
            mismatches++;
         end else begin
            want = pending_bits.pop_front();
            if (want !== rsp_bus.bit_res) begin
               $display("%0t: bit_res mismatch, expected %0b, got %0b",
                        $time, want, rsp_bus.bit_res);
               mismatches++;
            end
         end
      end
   end

   // run limit
   initial begin
      #(TIMEOUT_TIME);
      $display("fsk_zero_crossing_demodulator_core_tb NOT OK");
      $finish;
   end

   // test sequence
   initial begin
      req_bus.valid  = 1'b0;
      req_bus.action = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
      reset_mirror();
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_values();
      test_sample_extremes();
      test_zero_valued_sample();
      test_degenerate_config();
      test_free_running();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_gaps();
      test_back_pressure();
      test_threshold_extremes();
      test_nominal_tones();

      drain_bits(2 * SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("fsk_zero_crossing_demodulator_core_tb OK");
      end else begin
         $display("fsk_zero_crossing_demodulator_core_tb NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
rtl/fzcd_pkg.sv
rtl/fzcd_ifs.sv
rtl/fzcd_mul.sv
rtl/fzcd_div.sv
rtl/fzcd_run.sv
rtl/fsk_zero_crossing_demodulator_core.sv
rtl/fzcd_checker.sv
verif/fsk_zero_crossing_demodulator_core_tb.sv
